@@ design/ppts_pkg.sv @@
// ----------------------------------------------------------------------------
// ppts_pkg: shared types and constants of the periodic priority task scheduler
// Command codes, task states, the item structs of both channels and the table entry.
// ----------------------------------------------------------------------------
`default_nettype none
package ppts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam logic [7:0] NO_PRIORITY = 8'd255;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_YIELD   = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    TS_READY     = 3'd0,
    TS_RUNNING   = 3'd1,
    TS_BLOCKED   = 3'd2,
    TS_SUSPENDED = 3'd3,
    TS_DEAD      = 3'd4
  } tstate_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  task_index;
    logic [7:0]  priority_req;
    logic [31:0] period;
    logic [31:0] relative_deadline;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  created_id;
    logic        current_valid;
    logic [3:0]  current_id;
    logic [31:0] tick_now;
    logic [2:0]  task_state;
    logic [31:0] task_runs;
    logic [31:0] task_hits;
    logic [31:0] task_misses;
    logic [31:0] all_hits;
    logic [31:0] all_misses;
    logic [31:0] switch_total;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  prio;
    logic [31:0] period;
    logic [31:0] rel_dl;
    logic [31:0] release_t;
    logic [31:0] abs_dl;
    logic [31:0] runs;
    logic [31:0] hits;
    logic [31:0] misses;
  } entry_t;

endpackage
`default_nettype wire

@@ design/periodic_priority_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler
// Task table with create, tick, yield, suspend, resume and read commands,
// run by a small sequencer over one entry port of the table.
// ----------------------------------------------------------------------------
// Channel  Ports                    Handshake
// input    in_data                  taken when start && !busy
// result   out_valid, out_data      one-cycle strobe, one result per item
//
// Create, suspend, resume, read: latch, report. Tick: latch, scan, report.
// Yield: latch, finish of the running task if any, scan, pick if a ready
// task was found, report. The scan visits the created entries, one per cycle.
// The result appears the cycle after the report step; a new item may be
// taken in that same cycle. Reset is synchronous; the table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_priority_task_scheduler
  import ppts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  typedef enum logic [4:0] {
    SQ_IDLE   = 5'b00001,
    SQ_CUR    = 5'b00010,
    SQ_SCAN   = 5'b00100,
    SQ_PICK   = 5'b01000,
    SQ_REPORT = 5'b10000
  } seq_t;

  seq_t              sq_r, sq_nxt;
  entry_t            ent_r [MAX_TASKS];
  entry_t            rd_r;
  in_item_t          it_r, it_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt, cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  rep_r, rep_nxt, pick_r, pick_nxt, run_id_r, run_id_nxt;
  logic [7:0]        best_r, best_nxt;
  logic              found_r, found_nxt, run_v_r, run_v_nxt;
  logic [31:0]       tick_r, tick_nxt, hit_r, hit_nxt, miss_r, miss_nxt;
  logic [31:0]       sw_r, sw_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [IDX_W-1:0]  addr, raddr;
  entry_t            rd, wr;
  logic              we;
  logic              full, have, cr_ok;
  logic [31:0]       due;

  assign busy      = (sq_r != SQ_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign full      = (total_r == CNT_W'(MAX_TASKS));
  assign cr_ok     = (it_r.cmd == CMD_CREATE) && !full;
  assign have      = cr_ok || ({1'b0, it_r.task_index} < total_r);
  assign rd        = rd_r;
  assign due       = rd.release_t + rd.period;

  always_comb begin
    case (sq_r)
      SQ_CUR:  addr = run_id_r;
      SQ_SCAN: addr = cnt_r[IDX_W-1:0];
      SQ_PICK: addr = pick_r;
      default: addr = rep_r;
    endcase
  end

  // The entry that the next step works on is fetched into rd_r in the step before it.
  always_comb begin
    case (sq_nxt)
      SQ_CUR:  raddr = run_id_nxt;
      SQ_SCAN: raddr = cnt_nxt[IDX_W-1:0];
      SQ_PICK: raddr = pick_nxt;
      default: raddr = rep_nxt;
    endcase
  end

  always_comb begin
    sq_nxt = sq_r; it_nxt = it_r; total_nxt = total_r; cnt_nxt = cnt_r;
    rep_nxt = rep_r; pick_nxt = pick_r; run_id_nxt = run_id_r;
    best_nxt = best_r; found_nxt = found_r; run_v_nxt = run_v_r;
    tick_nxt = tick_r; hit_nxt = hit_r; miss_nxt = miss_r; sw_nxt = sw_r;
    out_valid_nxt = 1'b0; out_nxt = out_r;
    wr = rd; we = 1'b0;
    case (sq_r)
      SQ_IDLE: begin
        if (start) begin
          it_nxt    = in_data;
          cnt_nxt   = '0;
          best_nxt  = NO_PRIORITY;
          found_nxt = 1'b0;
          rep_nxt   = (in_data.cmd == CMD_CREATE && !full) ?
                      total_r[IDX_W-1:0] : in_data.task_index;
          case (in_data.cmd)
            CMD_TICK: begin
              tick_nxt = tick_r + 32'd1;
              sq_nxt   = SQ_SCAN;
            end
            CMD_YIELD: sq_nxt = run_v_r ? SQ_CUR : SQ_SCAN;
            default:   sq_nxt = SQ_REPORT;
          endcase
        end
      end
      SQ_CUR: begin
        // Finish the running task before choosing the next one.
        we           = 1'b1;
        wr.st        = TS_BLOCKED;
        wr.release_t = tick_r;
        wr.runs      = rd.runs + 32'd1;
        if (tick_r <= rd.abs_dl) begin
          wr.hits = rd.hits + 32'd1;
          hit_nxt = hit_r + 32'd1;
        end
        sq_nxt = SQ_SCAN;
      end
      SQ_SCAN: begin
        if (cnt_r == total_r) begin
          if (it_r.cmd == CMD_YIELD && found_r) sq_nxt = SQ_PICK;
          else sq_nxt = SQ_REPORT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (it_r.cmd == CMD_TICK) begin
            // The miss check sees the state before this tick's release.
            if ((rd.st == TS_READY || rd.st == TS_RUNNING) && rd.runs != 32'd0 &&
                tick_r > rd.abs_dl) begin
              we        = 1'b1;
              wr.misses = rd.misses + 32'd1;
              miss_nxt  = miss_r + 32'd1;
            end
            if (rd.st == TS_BLOCKED && rd.period != 32'd0 && tick_r >= due) begin
              we           = 1'b1;
              wr.st        = TS_READY;
              wr.release_t = tick_r;
              wr.abs_dl    = tick_r + rd.rel_dl;
            end
          end else if (rd.st == TS_READY && rd.prio < best_r) begin
            best_nxt  = rd.prio;
            pick_nxt  = cnt_r[IDX_W-1:0];
            found_nxt = 1'b1;
          end
        end
      end
      SQ_PICK: begin
        we         = 1'b1;
        wr.st      = TS_RUNNING;
        run_v_nxt  = 1'b1;
        run_id_nxt = pick_r;
        sw_nxt     = sw_r + 32'd1;
        sq_nxt     = SQ_REPORT;
      end
      SQ_REPORT: begin
        if (cr_ok) begin
          we           = 1'b1;
          wr.st        = TS_READY;
          wr.prio      = it_r.priority_req;
          wr.period    = it_r.period;
          wr.rel_dl    = it_r.relative_deadline;
          wr.release_t = '0;
          wr.abs_dl    = it_r.relative_deadline;
          wr.runs      = '0;
          wr.hits      = '0;
          wr.misses    = '0;
          total_nxt    = total_r + CNT_W'(1);
        end else if (have && it_r.cmd == CMD_SUSPEND) begin
          we    = 1'b1;
          wr.st = TS_SUSPENDED;
        end else if (have && it_r.cmd == CMD_RESUME) begin
          we    = 1'b1;
          wr.st = TS_READY;
        end
        case (it_r.cmd)
          CMD_CREATE:  out_nxt.ok = cr_ok;
          CMD_TICK:    out_nxt.ok = 1'b1;
          CMD_YIELD:   out_nxt.ok = 1'b1;
          CMD_SUSPEND: out_nxt.ok = have;
          CMD_RESUME:  out_nxt.ok = have;
          CMD_READ:    out_nxt.ok = have;
          default:     out_nxt.ok = 1'b0;
        endcase
        out_nxt.created_id    = cr_ok ? total_r[IDX_W-1:0] : '0;
        out_nxt.current_valid = run_v_r;
        out_nxt.current_id    = run_id_r;
        out_nxt.tick_now      = tick_r;
        out_nxt.task_state    = have ? wr.st : TS_DEAD;
        out_nxt.task_runs     = have ? wr.runs : '0;
        out_nxt.task_hits     = have ? wr.hits : '0;
        out_nxt.task_misses   = have ? wr.misses : '0;
        out_nxt.all_hits      = hit_r;
        out_nxt.all_misses    = miss_r;
        out_nxt.switch_total  = sw_r;
        out_valid_nxt         = 1'b1;
        sq_nxt                = SQ_IDLE;
      end
      default: sq_nxt = SQ_IDLE;
    endcase
  end

  // A write to the entry fetched for the next step is forwarded to it.
  always_ff @(posedge clk) begin
    if (we) ent_r[addr] <= wr;
    rd_r <= (we && addr == raddr) ? wr : ent_r[raddr];
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    cnt_r  <= cnt_nxt;
    rep_r  <= rep_nxt;
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_IDLE;
      total_r     <= '0;
      found_r     <= 1'b0;
      run_v_r     <= 1'b0;
      run_id_r    <= '0;
      tick_r      <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sq_r        <= sq_nxt;
      total_r     <= total_nxt;
      found_r     <= found_nxt;
      run_v_r     <= run_v_nxt;
      run_id_r    <= run_id_nxt;
      tick_r      <= tick_nxt;
      hit_r       <= hit_nxt;
      miss_r      <= miss_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(sq_r == SQ_REPORT)) else $error("result without report step");
  a_run_exists: assert property (@(posedge clk) disable iff (!rst_n)
    run_v_r |-> ({1'b0, run_id_r} < total_r)) else $error("running task not created");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == SQ_SCAN) |-> (cnt_r <= total_r)) else $error("scan past table end");

endmodule
`default_nettype wire

@@ bench/tb_periodic_priority_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_periodic_priority_task_scheduler: self-checking bench of the scheduler
// Drives create, tick, yield, suspend, resume, read and unknown-code items
// with random gaps, predicts every result from a task table model of its own
// and compares each result strobe field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_periodic_priority_task_scheduler;
  import ppts_pkg::*;

  class sched_scoreboard;
    entry_t       tbl [MAX_TASKS];
    int unsigned  n_tasks;
    logic [31:0]  now;
    logic         cur_valid;
    logic [3:0]   cur_id;
    logic [31:0]  hit_sum, miss_sum, switch_sum;
    out_item_t    pending [$];
    int unsigned  errors;

    function new();
      n_tasks = 0; now = '0; cur_valid = 1'b0; cur_id = '0;
      hit_sum = '0; miss_sum = '0; switch_sum = '0; errors = 0;
      foreach (tbl[i]) tbl[i] = '0;
    endfunction

    function void advance_tick();
      now = now + 32'd1;
      for (int i = 0; i < n_tasks; i++) begin
        if ((tbl[i].st == TS_READY || tbl[i].st == TS_RUNNING) && tbl[i].runs != 0 &&
            now > tbl[i].abs_dl) begin
          tbl[i].misses = tbl[i].misses + 32'd1;
          miss_sum = miss_sum + 32'd1;
        end
      end
      for (int i = 0; i < n_tasks; i++) begin
        if (tbl[i].st == TS_BLOCKED && tbl[i].period != 0 &&
            now >= tbl[i].release_t + tbl[i].period) begin
          tbl[i].st = TS_READY;
          tbl[i].release_t = now;
          tbl[i].abs_dl = now + tbl[i].rel_dl;
        end
      end
    endfunction

    function void dispatch();
      logic [7:0] best;
      int         pick;
      best = NO_PRIORITY;
      pick = -1;
      if (cur_valid) begin
        tbl[cur_id].st = TS_BLOCKED;
        tbl[cur_id].release_t = now;
        tbl[cur_id].runs = tbl[cur_id].runs + 32'd1;
        if (now <= tbl[cur_id].abs_dl) begin
          tbl[cur_id].hits = tbl[cur_id].hits + 32'd1;
          hit_sum = hit_sum + 32'd1;
        end
      end
      for (int i = 0; i < n_tasks; i++)
        if (tbl[i].st == TS_READY && tbl[i].prio < best) begin
          best = tbl[i].prio;
          pick = i;
        end
      if (pick >= 0) begin
        if (cur_valid && tbl[cur_id].st == TS_RUNNING) tbl[cur_id].st = TS_READY;
        cur_valid = 1'b1;
        cur_id = pick[3:0];
        tbl[pick].st = TS_RUNNING;
        switch_sum = switch_sum + 32'd1;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int        rep;
      logic      have;
      r = '0;
      rep = int'(it.task_index);
      have = (it.task_index < n_tasks);
      case (it.cmd)
        CMD_CREATE: begin
          if (n_tasks < MAX_TASKS) begin
            tbl[n_tasks] = '{st: TS_READY, prio: it.priority_req, period: it.period,
                             rel_dl: it.relative_deadline, release_t: '0,
                             abs_dl: it.relative_deadline, runs: '0, hits: '0,
                             misses: '0};
            r.ok = 1'b1;
            r.created_id = n_tasks[3:0];
            rep = n_tasks;
            have = 1'b1;
            n_tasks++;
          end
        end
        CMD_TICK: begin advance_tick(); r.ok = 1'b1; end
        CMD_YIELD: begin dispatch(); r.ok = 1'b1; end
        CMD_SUSPEND: if (have) begin tbl[rep].st = TS_SUSPENDED; r.ok = 1'b1; end
        CMD_RESUME: if (have) begin tbl[rep].st = TS_READY; r.ok = 1'b1; end
        CMD_READ: r.ok = have;
        default: ;
      endcase
      r.current_valid = cur_valid;
      r.current_id = cur_id;
      r.tick_now = now;
      if (have) begin
        r.task_state = tbl[rep].st;
        r.task_runs = tbl[rep].runs;
        r.task_hits = tbl[rep].hits;
        r.task_misses = tbl[rep].misses;
      end else begin
        r.task_state = TS_DEAD;
      end
      r.all_hits = hit_sum;
      r.all_misses = miss_sum;
      r.switch_total = switch_sum;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ok !== e.ok) begin
        $error("ok exp %0d got %0d", e.ok, got.ok); errors++;
      end
      if (got.created_id !== e.created_id) begin
        $error("created_id exp %0d got %0d", e.created_id, got.created_id); errors++;
      end
      if (got.current_valid !== e.current_valid) begin
        $error("current_valid exp %0d got %0d", e.current_valid, got.current_valid);
        errors++;
      end
      if (got.current_id !== e.current_id) begin
        $error("current_id exp %0d got %0d", e.current_id, got.current_id); errors++;
      end
      if (got.tick_now !== e.tick_now) begin
        $error("tick_now exp %0d got %0d", e.tick_now, got.tick_now); errors++;
      end
      if (got.task_state !== e.task_state) begin
        $error("task_state exp %0d got %0d", e.task_state, got.task_state); errors++;
      end
      if (got.task_runs !== e.task_runs) begin
        $error("task_runs exp %0d got %0d", e.task_runs, got.task_runs); errors++;
      end
      if (got.task_hits !== e.task_hits) begin
        $error("task_hits exp %0d got %0d", e.task_hits, got.task_hits); errors++;
      end
      if (got.task_misses !== e.task_misses) begin
        $error("task_misses exp %0d got %0d", e.task_misses, got.task_misses); errors++;
      end
      if (got.all_hits !== e.all_hits) begin
        $error("all_hits exp %0d got %0d", e.all_hits, got.all_hits); errors++;
      end
      if (got.all_misses !== e.all_misses) begin
        $error("all_misses exp %0d got %0d", e.all_misses, got.all_misses); errors++;
      end
      if (got.switch_total !== e.switch_total) begin
        $error("switch_total exp %0d got %0d", e.switch_total, got.switch_total);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  sched_scoreboard sb;
  int unsigned     idle_cycles;
  logic            timed_out;

  periodic_priority_task_scheduler i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Watchdog over cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
      timed_out   <= 1'b0;
    end else if (out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
    end
  end

  always @(posedge timed_out) begin
    $display("== FAIL ==");
    $finish;
  end

  // Start stays high from one item into the next when the gap is zero.
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_cmd(logic [2:0] c, logic [3:0] idx, logic [7:0] p,
                          logic [31:0] per, logic [31:0] dl);
    in_item_t it;
    it.cmd = c;
    it.task_index = idx;
    it.priority_req = p;
    it.period = per;
    it.relative_deadline = dl;
    send_item(it);
  endtask

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_TICK;
    if (r < 65) return CMD_YIELD;
    if (r < 75) return CMD_SUSPEND;
    if (r < 85) return CMD_RESUME;
    if (r < 96) return CMD_READ;
    if (r < 98) return CMD_CREATE;
    return 3'($urandom_range(6, 7));
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, unknown codes, extremes, a full table.
    send_cmd(CMD_YIELD, 4'd0, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_READ, 4'd15, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_SUSPEND, 4'd0, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_RESUME, 4'd3, 8'd0, 32'd0, 32'd0);
    send_cmd(3'd6, 4'd15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(3'd7, 4'd0, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_CREATE, 4'd0, 8'd255, 32'd0, 32'd0);
    send_cmd(CMD_CREATE, 4'd0, 8'd0, 32'd3, 32'd1);
    send_cmd(CMD_CREATE, 4'd15, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_CREATE, 4'd0, 8'd5, 32'd1, 32'd0);
    send_cmd(CMD_YIELD, 4'd1, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_YIELD, 4'd1, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_TICK, 4'd1, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_TICK, 4'd3, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_SUSPEND, 4'd1, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_RESUME, 4'd1, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_YIELD, 4'd0, 8'd0, 32'd0, 32'd0);
    send_cmd(CMD_READ, 4'd0, 8'd0, 32'd0, 32'd0);
    for (int i = 0; i < 13; i++)
      send_cmd(CMD_CREATE, 4'($urandom()), 8'($urandom()), pick_span(), pick_span());
    send_cmd(CMD_CREATE, 4'd7, 8'd1, 32'd1, 32'd1);
    send_cmd(CMD_READ, 4'd15, 8'd0, 32'd0, 32'd0);

    // Random: mostly valid traffic on a full table.
    for (int n = 0; n < 1620; n++)
      send_cmd(pick_cmd(), 4'($urandom()), 8'($urandom()), $urandom(), $urandom());
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
